>>> src/sldrv_pkg.sv
// Shared types, constants and the microcode table of the status LED pattern driver.
package sldrv_pkg;

  localparam int DUTY_BITS_DEF = 10;
  localparam int DUTY_W = 10;
  localparam int LVL_W = 12;
  localparam int CMD_W = 3;
  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int DVD_W = 32;
  localparam int DVS_W = 21;
  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int PC_W = 4;
  localparam int OP_W = 4;
  localparam int COND_W = 3;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_USB_UP = 3'd1;
  localparam logic [CMD_W-1:0] CMD_USB_FAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WIFI_UP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WIFI_TRY = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WIFI_FAIL = 3'd5;

  // Register indexes
  localparam logic [2:0] REG_SOLID = 3'd0;
  localparam logic [2:0] REG_BR_MIN = 3'd1;
  localparam logic [2:0] REG_BR_MAX = 3'd2;
  localparam logic [2:0] REG_BR_PERIOD = 3'd3;
  localparam logic [2:0] REG_BLINK_ON = 3'd4;
  localparam logic [2:0] REG_BLINK_OFF = 3'd5;
  localparam logic [2:0] REG_BLINK_CNT = 3'd6;
  localparam logic [2:0] REG_PAUSE = 3'd7;

  // Register reset values
  localparam logic [DUTY_W-1:0] RST_SOLID = 10'd320;
  localparam logic [DUTY_W-1:0] RST_BR_MIN = 10'd24;
  localparam logic [DUTY_W-1:0] RST_BR_MAX = 10'd360;
  localparam logic [CFG_W-1:0] RST_BR_PERIOD = 16'd2000;
  localparam logic [CFG_W-1:0] RST_BLINK_ON = 16'd120;
  localparam logic [CFG_W-1:0] RST_BLINK_OFF = 16'd120;
  localparam logic [3:0] RST_BLINK_CNT = 4'd3;
  localparam logic [CFG_W-1:0] RST_PAUSE = 16'd2000;

  // Sequencer steps
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_BLINK = 4'd1;
  localparam logic [PC_W-1:0] PC_SLOT = 4'd2;
  localparam logic [PC_W-1:0] PC_BREATH = 4'd3;
  localparam logic [PC_W-1:0] PC_MUL = 4'd4;
  localparam logic [PC_W-1:0] PC_HALF = 4'd5;
  localparam logic [PC_W-1:0] PC_EVAL = 4'd6;
  localparam logic [PC_W-1:0] PC_EMIT0 = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT1 = 4'd8;

  // Datapath operations
  localparam logic [OP_W-1:0] OP_IDLE = 4'd0;
  localparam logic [OP_W-1:0] OP_DIV_CYCLE = 4'd1;
  localparam logic [OP_W-1:0] OP_DIV_SLOT = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV_PERIOD = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV_HALF = 4'd5;
  localparam logic [OP_W-1:0] OP_EVAL = 4'd6;
  localparam logic [OP_W-1:0] OP_EMIT0 = 4'd7;
  localparam logic [OP_W-1:0] OP_EMIT1 = 4'd8;

  // Skip conditions
  localparam logic [COND_W-1:0] COND_NEVER = 3'd0;
  localparam logic [COND_W-1:0] COND_NO_BLINK = 3'd1;
  localparam logic [COND_W-1:0] COND_NO_BREATH = 3'd2;
  localparam logic [COND_W-1:0] COND_NO_CHG0 = 3'd3;
  localparam logic [COND_W-1:0] COND_NO_CHG1 = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0] skip_to;
    logic [PC_W-1:0] next_pc;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  // When the skip condition holds the step is passed over; otherwise its
  // operation runs to completion and control moves to next_pc.
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_IDLE:   w = '{OP_IDLE,       COND_NEVER,     PC_IDLE,   PC_BLINK};
      PC_BLINK:  w = '{OP_DIV_CYCLE,  COND_NO_BLINK,  PC_BREATH, PC_SLOT};
      PC_SLOT:   w = '{OP_DIV_SLOT,   COND_NEVER,     PC_BREATH, PC_BREATH};
      PC_BREATH: w = '{OP_DIV_PERIOD, COND_NO_BREATH, PC_EVAL,   PC_MUL};
      PC_MUL:    w = '{OP_MUL,        COND_NEVER,     PC_HALF,   PC_HALF};
      PC_HALF:   w = '{OP_DIV_HALF,   COND_NEVER,     PC_EVAL,   PC_EVAL};
      PC_EVAL:   w = '{OP_EVAL,       COND_NEVER,     PC_EMIT0,  PC_EMIT0};
      PC_EMIT0:  w = '{OP_EMIT0,      COND_NO_CHG0,   PC_EMIT1,  PC_EMIT1};
      PC_EMIT1:  w = '{OP_EMIT1,      COND_NO_CHG1,   PC_IDLE,   PC_IDLE};
      default:   w = '{OP_IDLE,       COND_NEVER,     PC_IDLE,   PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> src/sldrv_in_if.sv
// Input item channel: commands, flag values and tick times.
interface sldrv_in_if import sldrv_pkg::*; ();
  logic valid;
  logic ready;
  logic [CMD_W-1:0] cmd;
  logic flag_value;
  logic [TIME_W-1:0] now_ms;

  modport source(output valid, cmd, flag_value, now_ms, input ready);
  modport sink(input valid, cmd, flag_value, now_ms, output ready);
endinterface

>>> src/sldrv_out_if.sv
// Result channel: one duty update for one LED channel.
interface sldrv_out_if import sldrv_pkg::*; ();
  logic valid;
  logic ready;
  logic channel;
  logic [DUTY_W-1:0] duty;
  logic last;

  modport source(output valid, channel, duty, last, input ready);
  modport sink(input valid, channel, duty, last, output ready);
endinterface

>>> src/sldrv_div.sv
// Restoring divider, one quotient bit per cycle, shared by all modulo and divide steps.
module sldrv_div import sldrv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic busy;
  logic done;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] num;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0] shifted;
  logic [DVS_W:0] diff;
  logic fits;

  // The partial remainder stays below the divisor, so the shifted value
  // is below twice the divisor and one extra bit covers it.
  always_comb begin
    shifted = {rem, num[DVD_W-1]};
    fits = shifted >= {1'b0, dvs};
    diff = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        num <= req.dividend;
        dvs <= req.divisor;
        rem <= '0;
        cnt <= CNT_W'(DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        num <= {num[DVD_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = num;
  assign rsp.rem = rem;

endmodule

>>> src/status_led_pattern_driver_unit.sv
// Top level of the status LED pattern driver: register file, microcoded sequencer, datapath.
//
//   channel   direction  transaction
//   items     in         cmd, flag_value, now_ms
//   results   out        channel, duty, last
//   APB       in/out     eight registers at byte addresses 0 to 28
//
// An event item is handled as it is taken. A tick runs each modulo or divide
// on the shared radix-2 divider, two for a failure blink and two for WiFi
// breathing, alongside the other steps of the sequencer.
// Reset clears the link flags and the duty cache and loads register defaults.
// A result waits in the output register; the sequencer stalls on its emit step
// until that register is free, and a new item is taken once the tick is done.
module status_led_pattern_driver_unit import sldrv_pkg::*; #(
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  sldrv_in_if.sink            items,
  sldrv_out_if.source         results
);

  localparam logic [16:0] DUTY_MAX = 17'((17'd1 << DUTY_BITS) - 17'd1);

  // Configuration registers
  logic [DUTY_W-1:0] solid_duty;
  logic [DUTY_W-1:0] breath_min;
  logic [DUTY_W-1:0] breath_max;
  logic [CFG_W-1:0] breath_period_ms;
  logic [CFG_W-1:0] blink_on_ms;
  logic [CFG_W-1:0] blink_off_ms;
  logic [3:0] blink_count;
  logic [CFG_W-1:0] pause_ms;

  // Link state and duty cache
  logic usb_link_up;
  logic usb_link_fail;
  logic wifi_link_up;
  logic wifi_link_trying;
  logic wifi_link_fail;
  logic [DUTY_BITS-1:0] last_duty [2];
  logic [1:0] last_duty_known;

  // Sequencer and datapath
  logic [PC_W-1:0] pc;
  logic div_wait;
  logic [TIME_W-1:0] now_reg;
  logic lit;
  logic [DVS_W-1:0] phase_b;
  logic [CFG_W-1:0] phase_w;
  logic [25:0] prod;
  logic [LVL_W-1:0] quot;
  logic [DUTY_BITS-1:0] duty_usb;
  logic [DUTY_BITS-1:0] duty_wifi;
  logic [1:0] chg;

  // Output register
  logic out_valid;
  logic out_channel;
  logic [DUTY_W-1:0] out_duty;
  logic out_last;

  ucode_t cw;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic skip;
  logic step_done;
  logic div_fin;
  logic in_ready;
  logic in_acc;
  logic out_free;
  logic emit_go;
  logic cfg_wr;
  logic [2:0] cfg_idx;

  logic [16:0] slot;
  logic [DVS_W-1:0] window;
  logic [DVS_W-1:0] cycle;
  logic [CFG_W-2:0] half;
  logic [DUTY_W-1:0] span;
  logic [CFG_W-1:0] ramp;
  logic [LVL_W-1:0] breath_lvl;
  logic [LVL_W-1:0] lvl_usb;
  logic [LVL_W-1:0] lvl_wifi;
  logic [DUTY_BITS-1:0] duty_usb_c;
  logic [DUTY_BITS-1:0] duty_wifi_c;
  logic [LVL_W-1:0] solid_lvl;

  function automatic logic [DUTY_BITS-1:0] clamp_pwm(input logic [LVL_W-1:0] lvl);
    logic [DUTY_BITS-1:0] d;
    if ({5'd0, lvl} > DUTY_MAX) begin
      d = DUTY_MAX[DUTY_BITS-1:0];
    end else begin
      d = DUTY_BITS'(lvl);
    end
    return d;
  endfunction

  sldrv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cw = ucode(pc);
  assign in_ready = (pc == PC_IDLE);
  assign in_acc = items.valid && in_ready;
  assign out_free = !out_valid || results.ready;
  assign emit_go = !skip && (cw.op == OP_EMIT0 || cw.op == OP_EMIT1) && out_free;
  assign div_fin = div_wait && div_rsp.done;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  // Blink and breathing geometry from the configuration, and the breathing ramp from the phase.
  always_comb begin
    slot = {1'b0, blink_on_ms} + {1'b0, blink_off_ms};
    window = {4'd0, slot} * {17'd0, blink_count};
    cycle = window + {5'd0, pause_ms};
    half = breath_period_ms[CFG_W-1:1];
    span = (breath_max > breath_min) ? breath_max - breath_min : '0;
    ramp = (phase_w < {1'b0, half}) ? phase_w : breath_period_ms - phase_w;
    solid_lvl = {2'd0, solid_duty};
    breath_lvl = {2'd0, breath_min} + quot;
  end

  always_comb begin
    if (usb_link_fail) begin
      lvl_usb = lit ? solid_lvl : '0;
    end else begin
      lvl_usb = usb_link_up ? solid_lvl : '0;
    end
    if (wifi_link_fail) begin
      lvl_wifi = lit ? solid_lvl : '0;
    end else if (wifi_link_up) begin
      lvl_wifi = solid_lvl;
    end else if (wifi_link_trying) begin
      lvl_wifi = breath_lvl;
    end else begin
      lvl_wifi = '0;
    end
    duty_usb_c = clamp_pwm(lvl_usb);
    duty_wifi_c = clamp_pwm(lvl_wifi);
  end

  // Skip conditions of the current control word.
  always_comb begin
    case (cw.cond)
      COND_NEVER:     skip = 1'b0;
      COND_NO_BLINK:  skip = !(usb_link_fail || wifi_link_fail) || (window == '0);
      COND_NO_BREATH: skip = !(wifi_link_trying && !wifi_link_fail && !wifi_link_up) ||
                             (breath_period_ms < 16'd2);
      COND_NO_CHG0:   skip = !chg[0];
      COND_NO_CHG1:   skip = !chg[1];
      default:        skip = 1'b0;
    endcase
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.dividend = {TIME_W{1'b0}};
    div_req.divisor = {DVS_W{1'b0}};
    step_done = 1'b0;
    case (cw.op)
      OP_IDLE: begin
        step_done = in_acc && (items.cmd == CMD_TICK);
      end
      OP_DIV_CYCLE: begin
        div_req.dividend = now_reg;
        div_req.divisor = cycle;
        step_done = div_fin;
      end
      OP_DIV_SLOT: begin
        div_req.dividend = {11'd0, phase_b};
        div_req.divisor = {4'd0, slot};
        step_done = div_fin;
      end
      OP_DIV_PERIOD: begin
        div_req.dividend = now_reg;
        div_req.divisor = {5'd0, breath_period_ms};
        step_done = div_fin;
      end
      OP_MUL: begin
        step_done = 1'b1;
      end
      OP_DIV_HALF: begin
        div_req.dividend = {6'd0, prod};
        div_req.divisor = {6'd0, half};
        step_done = div_fin;
      end
      OP_EVAL: begin
        step_done = 1'b1;
      end
      OP_EMIT0, OP_EMIT1: begin
        step_done = out_free;
      end
      default: begin
        step_done = 1'b1;
      end
    endcase
    if ((cw.op == OP_DIV_CYCLE || cw.op == OP_DIV_SLOT || cw.op == OP_DIV_PERIOD ||
         cw.op == OP_DIV_HALF) && !skip && !div_wait) begin
      div_req.start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      solid_duty <= RST_SOLID;
      breath_min <= RST_BR_MIN;
      breath_max <= RST_BR_MAX;
      breath_period_ms <= RST_BR_PERIOD;
      blink_on_ms <= RST_BLINK_ON;
      blink_off_ms <= RST_BLINK_OFF;
      blink_count <= RST_BLINK_CNT;
      pause_ms <= RST_PAUSE;
      usb_link_up <= 1'b0;
      usb_link_fail <= 1'b0;
      wifi_link_up <= 1'b0;
      wifi_link_trying <= 1'b0;
      wifi_link_fail <= 1'b0;
      last_duty[0] <= '0;
      last_duty[1] <= '0;
      last_duty_known <= 2'b00;
      pc <= PC_IDLE;
      div_wait <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_SOLID:     solid_duty <= pwdata[DUTY_W-1:0];
          REG_BR_MIN:    breath_min <= pwdata[DUTY_W-1:0];
          REG_BR_MAX:    breath_max <= pwdata[DUTY_W-1:0];
          REG_BR_PERIOD: breath_period_ms <= pwdata[CFG_W-1:0];
          REG_BLINK_ON:  blink_on_ms <= pwdata[CFG_W-1:0];
          REG_BLINK_OFF: blink_off_ms <= pwdata[CFG_W-1:0];
          REG_BLINK_CNT: blink_count <= pwdata[3:0];
          REG_PAUSE:     pause_ms <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end

      if (div_req.start) begin
        div_wait <= 1'b1;
      end else if (div_rsp.done) begin
        div_wait <= 1'b0;
      end

      if (out_valid && results.ready && !emit_go) begin
        out_valid <= 1'b0;
      end

      if (skip) begin
        pc <= cw.skip_to;
      end else begin
        case (cw.op)
          OP_IDLE: begin
            if (in_acc) begin
              case (items.cmd)
                CMD_TICK: begin
                  now_reg <= items.now_ms;
                  lit <= 1'b0;
                  quot <= '0;
                end
                CMD_USB_UP: begin
                  usb_link_up <= items.flag_value;
                  if (items.flag_value) usb_link_fail <= 1'b0;
                end
                CMD_USB_FAIL: begin
                  usb_link_fail <= items.flag_value;
                  if (items.flag_value) usb_link_up <= 1'b0;
                end
                CMD_WIFI_UP: begin
                  wifi_link_up <= items.flag_value;
                  if (items.flag_value) begin
                    wifi_link_trying <= 1'b0;
                    wifi_link_fail <= 1'b0;
                  end
                end
                CMD_WIFI_TRY: begin
                  wifi_link_trying <= items.flag_value;
                  if (items.flag_value) begin
                    wifi_link_up <= 1'b0;
                    wifi_link_fail <= 1'b0;
                  end
                end
                CMD_WIFI_FAIL: begin
                  wifi_link_fail <= items.flag_value;
                  if (items.flag_value) begin
                    wifi_link_up <= 1'b0;
                    wifi_link_trying <= 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end
          OP_DIV_CYCLE: begin
            if (div_fin) phase_b <= div_rsp.rem;
          end
          OP_DIV_SLOT: begin
            // Lit inside the burst window and within the on part of a slot.
            if (div_fin) begin
              lit <= (phase_b < window) && (div_rsp.rem < {5'd0, blink_on_ms});
            end
          end
          OP_DIV_PERIOD: begin
            if (div_fin) phase_w <= div_rsp.rem[CFG_W-1:0];
          end
          OP_MUL: begin
            prod <= {16'd0, span} * {10'd0, ramp};
          end
          OP_DIV_HALF: begin
            // The ramp is at most half plus one, so the quotient is at most
            // twice the span and fits the level width.
            if (div_fin) quot <= div_rsp.quot[LVL_W-1:0];
          end
          OP_EVAL: begin
            duty_usb <= duty_usb_c;
            duty_wifi <= duty_wifi_c;
            chg[0] <= !last_duty_known[0] || (last_duty[0] != duty_usb_c);
            chg[1] <= !last_duty_known[1] || (last_duty[1] != duty_wifi_c);
          end
          OP_EMIT0: begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_channel <= 1'b0;
              out_duty <= DUTY_W'(duty_usb);
              out_last <= !chg[1];
              last_duty[0] <= duty_usb;
              last_duty_known[0] <= 1'b1;
            end
          end
          OP_EMIT1: begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_channel <= 1'b1;
              out_duty <= DUTY_W'(duty_wifi);
              out_last <= 1'b1;
              last_duty[1] <= duty_wifi;
              last_duty_known[1] <= 1'b1;
            end
          end
          default: ;
        endcase
        if (step_done) pc <= cw.next_pc;
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SOLID:     prdata = {22'd0, solid_duty};
      REG_BR_MIN:    prdata = {22'd0, breath_min};
      REG_BR_MAX:    prdata = {22'd0, breath_max};
      REG_BR_PERIOD: prdata = {16'd0, breath_period_ms};
      REG_BLINK_ON:  prdata = {16'd0, blink_on_ms};
      REG_BLINK_OFF: prdata = {16'd0, blink_off_ms};
      REG_BLINK_CNT: prdata = {28'd0, blink_count};
      REG_PAUSE:     prdata = {16'd0, pause_ms};
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign items.ready = in_ready;
  assign results.valid = out_valid;
  assign results.channel = out_channel;
  assign results.duty = out_duty;
  assign results.last = out_last;

  // A USB result that is not the last one is always followed by a WiFi result.
  a_nonlast_followed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (pc == PC_EMIT1 && chg[1]))
    else $error("non-final result without a pending WiFi update");

  // Every delivered duty is recorded in the cache.
  a_cache_filled: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_duty_known[out_channel])
    else $error("result issued without a cache entry");

  // The divider only finishes work the sequencer is waiting for.
  a_div_requested: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> div_wait)
    else $error("divider finished an unrequested operation");

  // No item is taken while a division is outstanding.
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_wait)
    else $error("input ready during a division");

endmodule

>>> test/status_led_pattern_driver_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the status LED pattern driver: directed table, then random phases.
module status_led_pattern_driver_unit_tb;
  import sldrv_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
  localparam logic [31:0] DUTY_LIMIT = (32'd1 << DUTY_BITS_DEF) - 32'd1;
  localparam int NOT_TYPED = -1;
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 90;

  typedef struct packed {
    logic chan;
    logic [DUTY_W-1:0] duty;
    logic last;
  } duty_res_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;
  typedef enum logic [2:0] {SET_RESET, SET_SHORT, SET_WIDE, SET_TOP, SET_ZERO} setting_e;

  typedef struct {
    row_kind_e kind;
    logic [2:0] code;  // command for an item row, register index for a register row
    logic flag;
    logic [31:0] value;
    int n_typed;
    duty_res_t r0;
    duty_res_t r1;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  sldrv_in_if item_if ();
  sldrv_out_if res_if ();

  status_led_pattern_driver_unit dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .items(item_if), .results(res_if)
  );

  // Shadow of the register file and of the block's link and cache state.
  logic [DUTY_W-1:0] r_solid, r_bmin, r_bmax;
  logic [CFG_W-1:0] r_period, r_on, r_off, r_pause;
  logic [3:0] r_cnt;
  logic usb_up, usb_fail, wifi_up, wifi_try, wifi_fail;
  logic [DUTY_W-1:0] duty_seen [2];
  logic duty_known [2];

  duty_res_t pending_duties [$];
  stim_row_t dir_rows [$];
  int mismatches = 0;
  bit in_flight = 1'b0;
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  int hold_req = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status_led_pattern_driver_unit verification failed");
    $finish;
  end

  function automatic duty_res_t res(input logic c, input logic [DUTY_W-1:0] d, input logic l);
    duty_res_t r;
    r.chan = c;
    r.duty = d;
    r.last = l;
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic [CMD_W-1:0] c, input logic f,
                                         input logic [31:0] t, input int n = NOT_TYPED,
                                         input duty_res_t a = '0, input duty_res_t b = '0);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.code = c;
    row.flag = f;
    row.value = t;
    row.n_typed = n;
    row.r0 = a;
    row.r1 = b;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [2:0] idx, input logic [31:0] v);
    stim_row_t row;
    row = item_row(CMD_TICK, 1'b0, v);
    row.kind = ROW_REG;
    row.code = idx;
    return row;
  endfunction

  function automatic logic blink_lit(input logic [31:0] t);
    logic [31:0] slot, window, cyc, ph;
    slot = 32'(r_on) + 32'(r_off);
    window = slot * 32'(r_cnt);
    cyc = window + 32'(r_pause);
    if (cyc == 0 || window == 0 || slot == 0) return 1'b0;
    ph = t % cyc;
    if (ph >= window) return 1'b0;
    return (ph % slot) < 32'(r_on);
  endfunction

  function automatic logic [31:0] breath_duty(input logic [31:0] t);
    logic [31:0] half, ph, ramp, span;
    if (r_period < 16'd2) return 32'(r_bmin);
    half = 32'(r_period) / 32'd2;
    ph = t % 32'(r_period);
    ramp = (ph < half) ? ph : 32'(r_period) - ph;
    span = (r_bmax > r_bmin) ? 32'(r_bmax) - 32'(r_bmin) : 32'd0;
    return 32'(r_bmin) + (span * ramp) / half;
  endfunction

  // Priority per channel: failure blink, then solid, then (WiFi) breathing, else dark.
  function automatic logic [31:0] raw_duty(input logic chan, input logic [31:0] t);
    if (!chan) begin
      if (usb_fail) return blink_lit(t) ? 32'(r_solid) : 32'd0;
      return usb_up ? 32'(r_solid) : 32'd0;
    end
    if (wifi_fail) return blink_lit(t) ? 32'(r_solid) : 32'd0;
    if (wifi_up) return 32'(r_solid);
    if (wifi_try) return breath_duty(t);
    return 32'd0;
  endfunction

  function automatic int next_duty_updates(input logic [CMD_W-1:0] c, input logic f,
                                           input logic [31:0] t, output duty_res_t got [2]);
    int n;
    logic [31:0] d;
    n = 0;
    got[0] = '0;
    got[1] = '0;
    case (c)
      CMD_USB_UP: begin
        usb_up = f;
        if (f) usb_fail = 1'b0;
      end
      CMD_USB_FAIL: begin
        usb_fail = f;
        if (f) usb_up = 1'b0;
      end
      CMD_WIFI_UP: begin
        wifi_up = f;
        if (f) begin
          wifi_try = 1'b0;
          wifi_fail = 1'b0;
        end
      end
      CMD_WIFI_TRY: begin
        wifi_try = f;
        if (f) begin
          wifi_up = 1'b0;
          wifi_fail = 1'b0;
        end
      end
      CMD_WIFI_FAIL: begin
        wifi_fail = f;
        if (f) begin
          wifi_up = 1'b0;
          wifi_try = 1'b0;
        end
      end
      CMD_TICK: begin
        for (int ch = 0; ch < 2; ch++) begin
          d = raw_duty(ch[0], t);
          if (d > DUTY_LIMIT) d = DUTY_LIMIT;
          if (!(duty_known[ch] && duty_seen[ch] == d[DUTY_W-1:0])) begin
            duty_seen[ch] = d[DUTY_W-1:0];
            duty_known[ch] = 1'b1;
            got[n] = res(ch[0], d[DUTY_W-1:0], 1'b0);
            n++;
          end
        end
        if (n > 0) got[n-1].last = 1'b1;
      end
      default: ;
    endcase
    return n;
  endfunction

  task automatic note_mismatch(input string what, input duty_res_t want, input duty_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d (%s) at %0t: expected ch=%0d duty=%0d last=%0d, got ch=%0d duty=%0d last=%0d",
               mismatches, what, $time, want.chan, want.duty, want.last,
               got.chan, got.duty, got.last);
  endtask

  always @(posedge clk) begin : result_check
    duty_res_t want;
    duty_res_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got = res(res_if.channel, res_if.duty, res_if.last);
      if (pending_duties.size() == 0) begin
        note_mismatch("result with nothing expected", '0, got);
      end else begin
        want = pending_duties.pop_front();
        if (got.chan !== want.chan) note_mismatch("channel", want, got);
        if (got.duty !== want.duty) note_mismatch("duty", want, got);
        if (got.last !== want.last) note_mismatch("last", want, got);
      end
    end
  end

  initial begin : result_sink
    int stall;
    res_if.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = snk_idle_en ? $urandom_range(0, 8) : 0;
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction with valid
  // still high, so a back-to-back item does not toggle it.
  task automatic offer_item(input logic [CMD_W-1:0] c, input logic f, input logic [31:0] t,
                            input int n_typed = NOT_TYPED,
                            input duty_res_t a = '0, input duty_res_t b = '0);
    int gap;
    int n;
    duty_res_t got [2];
    gap = src_idle_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.cmd <= c;
    item_if.flag_value <= f;
    item_if.now_ms <= t;
    in_flight = 1'b1;
    do @(posedge clk); while (!item_if.ready);
    n = next_duty_updates(c, f, t, got);
    if (n_typed != NOT_TYPED) begin
      n = n_typed;
      got[0] = a;
      got[1] = b;
    end
    for (int k = 0; k < n; k++) pending_duties.push_back(got[k]);
    @(negedge clk);
  endtask

  // A tick that changes no duty gives no result, so allow for its full run before going idle.
  task automatic settle_block();
    if (!in_flight) return;
    item_if.valid <= 1'b0;
    while (pending_duties.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    in_flight = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SOLID:     r_solid = v[DUTY_W-1:0];
      REG_BR_MIN:    r_bmin = v[DUTY_W-1:0];
      REG_BR_MAX:    r_bmax = v[DUTY_W-1:0];
      REG_BR_PERIOD: r_period = v[CFG_W-1:0];
      REG_BLINK_ON:  r_on = v[CFG_W-1:0];
      REG_BLINK_OFF: r_off = v[CFG_W-1:0];
      REG_BLINK_CNT: r_cnt = v[3:0];
      REG_PAUSE:     r_pause = v[CFG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_setting(input setting_e s);
    logic [31:0] v [8];
    case (s)
      SET_RESET: begin
        v[REG_SOLID] = 32'(RST_SOLID);
        v[REG_BR_MIN] = 32'(RST_BR_MIN);
        v[REG_BR_MAX] = 32'(RST_BR_MAX);
        v[REG_BR_PERIOD] = 32'(RST_BR_PERIOD);
        v[REG_BLINK_ON] = 32'(RST_BLINK_ON);
        v[REG_BLINK_OFF] = 32'(RST_BLINK_OFF);
        v[REG_BLINK_CNT] = 32'(RST_BLINK_CNT);
        v[REG_PAUSE] = 32'(RST_PAUSE);
      end
      SET_SHORT: begin
        v[REG_SOLID] = $urandom_range(0, 1023);
        v[REG_BR_MIN] = $urandom_range(0, 1023);
        v[REG_BR_MAX] = $urandom_range(0, 1023);
        v[REG_BR_PERIOD] = $urandom_range(2, 400);
        v[REG_BLINK_ON] = $urandom_range(1, 60);
        v[REG_BLINK_OFF] = $urandom_range(0, 60);
        v[REG_BLINK_CNT] = $urandom_range(1, 15);
        v[REG_PAUSE] = $urandom_range(0, 300);
      end
      SET_WIDE: foreach (v[i]) v[i] = $urandom();
      SET_TOP:  foreach (v[i]) v[i] = '1;
      default:  foreach (v[i]) v[i] = '0;
    endcase
    for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
  endtask

  initial begin : stimulus
    setting_e style;
    logic [31:0] now_base;
    logic [31:0] t;
    int step_max;
    int pick;
    int done;
    logic [CMD_W-1:0] flag_cmds [5];

    flag_cmds = '{CMD_USB_UP, CMD_USB_FAIL, CMD_WIFI_UP, CMD_WIFI_TRY, CMD_WIFI_FAIL};
    item_if.valid = 1'b0;
    item_if.cmd = CMD_TICK;
    item_if.flag_value = 1'b0;
    item_if.now_ms = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    r_solid = RST_SOLID;
    r_bmin = RST_BR_MIN;
    r_bmax = RST_BR_MAX;
    r_period = RST_BR_PERIOD;
    r_on = RST_BLINK_ON;
    r_off = RST_BLINK_OFF;
    r_cnt = RST_BLINK_CNT;
    r_pause = RST_PAUSE;
    {usb_up, usb_fail, wifi_up, wifi_try, wifi_fail} = '0;
    duty_seen = '{'0, '0};
    duty_known = '{1'b0, 1'b0};

    // Directed table. Typed rows: first tick after reset, unused commands, extremes.
    dir_rows.push_back(item_row(CMD_TICK, 1'b0, 32'd0, 2,
                                res(1'b0, 10'd0, 1'b0), res(1'b1, 10'd0, 1'b1)));
    dir_rows.push_back(item_row(CMD_SPARE6, 1'b1, 32'hFFFF_FFFF, 0));
    dir_rows.push_back(item_row(CMD_SPARE7, 1'b0, 32'd0, 0));
    dir_rows.push_back(item_row(CMD_TICK, 1'b1, 32'hFFFF_FFFF, 0));
    dir_rows.push_back(item_row(CMD_USB_UP, 1'b1, 32'd0));
    dir_rows.push_back(item_row(CMD_TICK, 1'b0, 32'd5, 1, res(1'b0, RST_SOLID, 1'b1)));
    dir_rows.push_back(item_row(CMD_WIFI_TRY, 1'b1, 32'd0));
    dir_rows.push_back(item_row(CMD_TICK, 1'b0, 32'd0));
    dir_rows.push_back(item_row(CMD_TICK, 1'b0, 32'd1000));
    dir_rows.push_back(item_row(CMD_USB_FAIL, 1'b1, 32'd0));
    dir_rows.push_back(item_row(CMD_TICK, 1'b0, 32'd130));
    dir_rows.push_back(item_row(CMD_TICK, 1'b0, 32'd2720));
    dir_rows.push_back(item_row(CMD_WIFI_FAIL, 1'b1, 32'd0));
    dir_rows.push_back(item_row(CMD_TICK, 1'b0, 32'd1000));
    dir_rows.push_back(item_row(CMD_WIFI_UP, 1'b1, 32'd0));
    dir_rows.push_back(item_row(CMD_TICK, 1'b0, 32'd0));
    dir_rows.push_back(item_row(CMD_USB_FAIL, 1'b0, 32'd0));
    // Bits above the register width are dropped; odd period overshoots and is clamped.
    dir_rows.push_back(reg_row(REG_SOLID, 32'hFFFF_FFFF));
    dir_rows.push_back(reg_row(REG_BR_MIN, 32'd0));
    dir_rows.push_back(reg_row(REG_BR_MAX, 32'd1023));
    dir_rows.push_back(reg_row(REG_BR_PERIOD, 32'd3));
    dir_rows.push_back(item_row(CMD_USB_UP, 1'b1, 32'd0));
    dir_rows.push_back(item_row(CMD_WIFI_TRY, 1'b1, 32'd0));
    dir_rows.push_back(item_row(CMD_TICK, 1'b0, 32'd1, 2,
                                res(1'b0, 10'd1023, 1'b0), res(1'b1, 10'd1023, 1'b1)));
    // Inverted breath bounds, then a period too short to ramp.
    dir_rows.push_back(reg_row(REG_BR_MIN, 32'd500));
    dir_rows.push_back(reg_row(REG_BR_MAX, 32'd100));
    dir_rows.push_back(item_row(CMD_TICK, 1'b0, 32'd2));
    dir_rows.push_back(reg_row(REG_BR_PERIOD, 32'd1));
    dir_rows.push_back(reg_row(REG_BR_MIN, 32'd7));
    dir_rows.push_back(item_row(CMD_TICK, 1'b0, 32'd9));
    // Empty blink cycle, then a zero burst window with a nonzero pause.
    dir_rows.push_back(reg_row(REG_BLINK_ON, 32'd0));
    dir_rows.push_back(reg_row(REG_BLINK_OFF, 32'd0));
    dir_rows.push_back(reg_row(REG_BLINK_CNT, 32'd0));
    dir_rows.push_back(reg_row(REG_PAUSE, 32'd0));
    dir_rows.push_back(item_row(CMD_USB_FAIL, 1'b1, 32'd0));
    dir_rows.push_back(item_row(CMD_TICK, 1'b0, 32'd0, 1, res(1'b0, 10'd0, 1'b1)));
    dir_rows.push_back(reg_row(REG_BLINK_ON, 32'd4));
    dir_rows.push_back(reg_row(REG_PAUSE, 32'd5));
    dir_rows.push_back(item_row(CMD_TICK, 1'b0, 32'd0, 0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        settle_block();
        write_reg(dir_rows[i].code, dir_rows[i].value);
      end else begin
        offer_item(dir_rows[i].code, dir_rows[i].flag, dir_rows[i].value,
                   dir_rows[i].n_typed, dir_rows[i].r0, dir_rows[i].r1);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle_block();
      case (ph)
        0: style = SET_SHORT;
        1: style = SET_TOP;
        2: style = SET_ZERO;
        3: style = SET_WIDE;
        4: style = SET_RESET;
        5: style = SET_SHORT;
        default: style = ($urandom_range(0, 9) < 6) ? SET_SHORT : setting_e'($urandom_range(0, 4));
      endcase
      load_setting(style);
      src_idle_en = ($urandom_range(0, 3) != 0);
      snk_idle_en = ($urandom_range(0, 3) != 0);
      // One phase keeps the receiver stalled while items keep coming, to back up the block.
      if (ph == 5) begin
        src_idle_en = 1'b0;
        hold_req = LONG_HOLD_CYCLES;
      end
      step_max = (style == SET_SHORT) ? 150 : 5000;
      now_base = $urandom();
      done = 0;
      while (done < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          now_base += $urandom_range(0, step_max);
          t = ($urandom_range(0, 99) < 15) ? $urandom() : now_base;
          offer_item(CMD_TICK, 1'($urandom_range(0, 1)), t);
          done++;
        end else if (pick < 95) begin
          offer_item(flag_cmds[$urandom_range(0, 4)], ($urandom_range(0, 3) != 0), $urandom());
          done++;
        end else begin
          offer_item($urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7, 1'($urandom_range(0, 1)),
                     $urandom());
        end
      end
    end

    settle_block();
    if (mismatches == 0 && pending_duties.size() == 0) begin
      $display("status_led_pattern_driver_unit verification clean");
    end else begin
      $display("status_led_pattern_driver_unit verification failed");
    end
    $finish;
  end

endmodule
